FILE: hdl/pts_pkg.sv
`timescale 1ns / 1ps
package pts_pkg;

   localparam int unsigned PORT_COUNT_DEFAULT = 65536;
   localparam int unsigned CONN_SLOTS_DEFAULT = 1024;
   localparam logic [31:0] AGE_INTERVAL_RESET = 32'd15000000;

   localparam logic [2:0] CMD_SET_FILTER = 3'd0;
   localparam logic [2:0] CMD_NEW_CONN   = 3'd1;
   localparam logic [2:0] CMD_PACKET     = 3'd2;
   localparam logic [2:0] CMD_FLUSH_AGE  = 3'd3;
   localparam logic [2:0] CMD_READ_PORT  = 3'd4;

   localparam int REQ_DATA_W = 104;
   localparam int RSP_DATA_W = 232;

   typedef enum logic [2:0] {
      KIND_FILTER,
      KIND_CONN,
      KIND_PACKET,
      KIND_FLUSH,
      KIND_READ,
      KIND_NONE
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [15:0] port_a;
      logic [15:0] port_b;
      logic        include_req;
      logic [9:0]  conn_id;
      logic [15:0] ip_length;
      logic [39:0] time_us;
      logic        port_a_ok;
      logic        port_b_ok;
      logic        conn_ok;
   } item_type;

   typedef struct packed {
      logic        touched;
      logic [39:0] int_bytes;
      logic [31:0] int_packets;
      logic [11:0] int_active;
      logic [39:0] lat_bytes;
      logic [31:0] lat_packets;
      logic [11:0] lat_active;
      logic [63:0] tot_bytes;
      logic [47:0] tot_packets;
      logic [31:0] tot_conns;
   } rec_type;

   typedef struct packed {
      logic        valid;
      logic        active;
      logic        has_a;
      logic        has_b;
      logic [15:0] pa;
      logic [15:0] pb;
   } slot_type;

   typedef struct packed {
      logic        port_seen;
      logic [39:0] last_bytes;
      logic [31:0] last_packets;
      logic [11:0] last_active;
      logic [63:0] total_bytes;
      logic [47:0] total_packets;
      logic [31:0] total_conns;
      logic        aged;
   } result_type;

   typedef enum logic [2:0] {
      OP_CONN,
      OP_PKT,
      OP_ACT,
      OP_READ,
      OP_AGE
   } op_type;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILT,
      ST_PA,
      ST_PB,
      ST_PT,
      ST_PRD,
      ST_PWR,
      ST_POST,
      ST_MARK_RD,
      ST_MARK_WR,
      ST_AGE_CHECK,
      ST_SLOT_RD,
      ST_SLOT_CHK,
      ST_SLOT_A,
      ST_SLOT_B,
      ST_SLOT_T,
      ST_SLOT_WR,
      ST_SLOT_NEXT,
      ST_SWEEP,
      ST_SWEEP_NEXT,
      ST_DONE
   } state_type;

endpackage

FILE: hdl/per_port_traffic_statistics.sv
`timescale 1ns / 1ps
// Per-port traffic counters with a port filter map. Every command gives one response
// transaction. After reset a clearing pass over all memories runs with req_tready low.
// All port records sit in one memory; each touch is a dispatch state and a read-modify-write
// (ST_PRD, ST_PWR). A new connection or a packet touches both ports, the total record
// and the connection slot. Aging, on flush or when a packet's time passes the interval,
// walks every connection slot, updating the port records of each active one, and then
// every port record. A filter write walks each port in its range. A two-entry queue
// takes commands while the engine works.
module per_port_traffic_statistics import pts_pkg::*; #(
   parameter int unsigned PORT_COUNT = PORT_COUNT_DEFAULT,
   parameter int unsigned CONN_SLOTS = CONN_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // port_a, port_b, include_req, conn_id, ip_length, time_us, zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   // command
   input  logic [2:0]            req_tuser,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // port_seen, last_bytes, last_packets, last_active, total_bytes,
   // total_packets, total_conns, aged, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data
);

   logic [31:0] interval_ff, interval_in;
   logic        clearing;
   logic        q_valid;
   item_type    q_item;
   logic        q_pop;
   result_type  result;

   assign interval_in = csr_wr_en ? csr_wr_data : interval_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         interval_ff <= AGE_INTERVAL_RESET;
      end else begin
         interval_ff <= interval_in;
      end
   end

   pts_front #(
      .PORT_COUNT(PORT_COUNT),
      .CONN_SLOTS(CONN_SLOTS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .clearing   (clearing),
      .q_valid    (q_valid),
      .q_item     (q_item),
      .q_pop      (q_pop)
   );

   pts_back #(
      .PORT_COUNT(PORT_COUNT),
      .CONN_SLOTS(CONN_SLOTS)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .aging_period (interval_ff),
      .q_valid      (q_valid),
      .q_item       (q_item),
      .q_pop        (q_pop),
      .clearing     (clearing),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_result   (result)
   );

   assign rsp_tdata = {2'b00, result.aged, result.total_conns, result.total_packets,
                       result.total_bytes, result.last_active, result.last_packets,
                       result.last_bytes, result.port_seen};

   // no command enters while the memories are being cleared
   assert property (@(posedge clock) disable iff (reset) clearing |-> !req_tready)
      else $error("command accepted during clearing pass");

   assert property (@(posedge clock) disable iff (reset) clearing |-> !q_valid)
      else $error("queue holds a command during clearing pass");

   assert property (@(posedge clock) disable iff (reset) clearing |-> !rsp_tvalid)
      else $error("response raised during clearing pass");

   assert property (@(posedge clock) (!reset && $past(reset)) |-> clearing)
      else $error("clearing pass did not start after reset");

endmodule

FILE: hdl/pts_front.sv
`timescale 1ns / 1ps
module pts_front import pts_pkg::*; #(
   parameter int unsigned PORT_COUNT = PORT_COUNT_DEFAULT,
   parameter int unsigned CONN_SLOTS = CONN_SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  clearing,
   output logic                  q_valid,
   output item_type              q_item,
   input  logic                  q_pop
);

   item_type   new_item;
   item_type   entries_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept;

   always_comb begin
      new_item.port_a      = req_tdata[15:0];
      new_item.port_b      = req_tdata[31:16];
      new_item.include_req = req_tdata[32];
      new_item.conn_id     = req_tdata[42:33];
      new_item.ip_length   = req_tdata[58:43];
      new_item.time_us     = req_tdata[98:59];
      new_item.port_a_ok   = 32'(req_tdata[15:0]) < PORT_COUNT;
      new_item.port_b_ok   = 32'(req_tdata[31:16]) < PORT_COUNT;
      new_item.conn_ok     = 32'(req_tdata[42:33]) < CONN_SLOTS;
      case (req_tuser)
         CMD_SET_FILTER: new_item.kind = KIND_FILTER;
         CMD_NEW_CONN:   new_item.kind = KIND_CONN;
         CMD_PACKET:     new_item.kind = KIND_PACKET;
         CMD_FLUSH_AGE:  new_item.kind = KIND_FLUSH;
         CMD_READ_PORT:  new_item.kind = KIND_READ;
         default:        new_item.kind = KIND_NONE;
      endcase
   end

   assign req_tready = (count_ff != 2'd2) && !clearing;
   assign accept     = req_tvalid && req_tready;
   assign q_valid    = count_ff != 2'd0;
   assign q_item     = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (accept) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (q_pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (accept && !q_pop) begin
         count_in = count_ff + 2'd1;
      end else if (!accept && q_pop) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entries_ff[wr_ptr_ff] <= new_item;
      end
   end

endmodule

FILE: hdl/pts_back.sv
`timescale 1ns / 1ps
module pts_back import pts_pkg::*; #(
   parameter int unsigned PORT_COUNT = PORT_COUNT_DEFAULT,
   parameter int unsigned CONN_SLOTS = CONN_SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic [31:0] aging_period,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        clearing,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output result_type  rsp_result
);

   localparam int PW = $clog2(PORT_COUNT);
   localparam int CW = $clog2(CONN_SLOTS);
   localparam int unsigned MAX_DEPTH = (PORT_COUNT > CONN_SLOTS) ? PORT_COUNT : CONN_SLOTS;
   localparam int IW = $clog2(MAX_DEPTH);

   rec_type    rec_mem [PORT_COUNT];
   logic       excl_mem [PORT_COUNT];
   slot_type   conn_mem [CONN_SLOTS];
   rec_type    rec_q;
   logic       excl_q;
   slot_type   conn_q;

   logic          rec_we;
   logic [PW-1:0] rec_wa;
   rec_type       rec_wd;
   logic          excl_we;
   logic [PW-1:0] excl_wa;
   logic          excl_wd;
   logic          conn_we;
   logic [CW-1:0] conn_wa;
   slot_type      conn_wd;

   state_type     state_ff, state_in;
   state_type     ret_ff, ret_in;
   op_type        op_ff, op_in;
   item_type      item_ff, item_in;
   logic [PW-1:0] cur_ff, cur_in;
   logic [CW-1:0] caddr_ff, caddr_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic [PW-1:0] flast_ff, flast_in;
   logic          has_a_ff, has_a_in;
   logic          has_b_ff, has_b_in;
   logic          from_pkt_ff, from_pkt_in;
   slot_type      slot_ff, slot_in;
   result_type    res_ff, res_in;
   logic [39:0]   last_age_ff, last_age_in;
   logic          rsp_valid_ff, rsp_valid_in;
   result_type    rsp_res_ff, rsp_res_in;

   rec_type       upd;
   rec_type       clear_rec;
   logic [16:0]   fstart;
   logic [16:0]   fend;
   logic [39:0]   age_delta;
   logic [CW-1:0] cid_idx;

   assign clearing   = state_ff == ST_CLEAR;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_res_ff;
   assign cid_idx    = CW'(item_ff.conn_id);
   assign age_delta  = item_ff.time_us - last_age_ff;

   always_ff @(posedge clock) begin
      if (rec_we) begin
         rec_mem[rec_wa] <= rec_wd;
      end
      rec_q <= rec_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (excl_we) begin
         excl_mem[excl_wa] <= excl_wd;
      end
      excl_q <= excl_mem[cur_ff];
   end

   always_ff @(posedge clock) begin
      if (conn_we) begin
         conn_mem[conn_wa] <= conn_wd;
      end
      conn_q <= conn_mem[caddr_ff];
   end

   // record update for the port op in flight
   always_comb begin
      upd = rec_q;
      case (op_ff)
         OP_CONN: begin
            if (!excl_q) begin
               upd.touched   = 1'b1;
               upd.tot_conns = rec_q.tot_conns + 32'd1;
            end
         end
         OP_PKT: begin
            if (!excl_q) begin
               upd.touched     = 1'b1;
               upd.int_bytes   = rec_q.int_bytes + 40'(item_ff.ip_length);
               upd.int_packets = rec_q.int_packets + 32'd1;
            end
         end
         OP_ACT: begin
            upd.int_active = rec_q.int_active + 12'd1;
         end
         OP_AGE: begin
            if (rec_q.touched) begin
               upd.lat_bytes   = rec_q.int_bytes;
               upd.lat_packets = rec_q.int_packets;
               upd.lat_active  = rec_q.int_active;
               upd.tot_bytes   = rec_q.tot_bytes + 64'(rec_q.int_bytes);
               upd.tot_packets = rec_q.tot_packets + 48'(rec_q.int_packets);
               upd.int_bytes   = '0;
               upd.int_packets = '0;
               upd.int_active  = '0;
            end
         end
         default: begin
            upd = rec_q;
         end
      endcase
   end

   always_comb begin
      clear_rec         = '0;
      clear_rec.touched = idx_ff == '0;
      fstart = (q_item.port_a == 16'd0) ? 17'd1 : {1'b0, q_item.port_a};
      fend   = ({1'b0, q_item.port_b} > 17'(PORT_COUNT - 1)) ?
               17'(PORT_COUNT - 1) : {1'b0, q_item.port_b};
   end

   always_comb begin
      state_in     = state_ff;
      ret_in       = ret_ff;
      op_in        = op_ff;
      item_in      = item_ff;
      cur_in       = cur_ff;
      caddr_in     = caddr_ff;
      idx_in       = idx_ff;
      flast_in     = flast_ff;
      has_a_in     = has_a_ff;
      has_b_in     = has_b_ff;
      from_pkt_in  = from_pkt_ff;
      slot_in      = slot_ff;
      res_in       = res_ff;
      last_age_in  = last_age_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      q_pop        = 1'b0;
      rec_we       = 1'b0;
      rec_wa       = cur_ff;
      rec_wd       = upd;
      excl_we      = 1'b0;
      excl_wa      = idx_ff[PW-1:0];
      excl_wd      = 1'b0;
      conn_we      = 1'b0;
      conn_wa      = caddr_ff;
      conn_wd      = conn_q;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_CLEAR: begin
            rec_we  = 32'(idx_ff) < PORT_COUNT;
            rec_wa  = idx_ff[PW-1:0];
            rec_wd  = clear_rec;
            excl_we = 32'(idx_ff) < PORT_COUNT;
            excl_wd = 1'b0;
            conn_we = 32'(idx_ff) < CONN_SLOTS;
            conn_wa = idx_ff[CW-1:0];
            conn_wd = '0;
            if (idx_ff == IW'(MAX_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (q_valid) begin
               q_pop       = 1'b1;
               item_in     = q_item;
               res_in      = '0;
               has_a_in    = 1'b0;
               has_b_in    = 1'b0;
               from_pkt_in = 1'b0;
               case (q_item.kind)
                  KIND_FILTER: begin
                     if (fstart <= fend) begin
                        idx_in   = IW'(fstart);
                        flast_in = PW'(fend);
                        state_in = ST_FILT;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  KIND_CONN: begin
                     state_in = q_item.conn_ok ? ST_PA : ST_DONE;
                  end
                  KIND_PACKET: begin
                     from_pkt_in = 1'b1;
                     state_in    = ST_PA;
                  end
                  KIND_FLUSH: begin
                     idx_in   = '0;
                     caddr_in = '0;
                     state_in = ST_SLOT_RD;
                  end
                  KIND_READ: begin
                     if (q_item.port_a_ok) begin
                        cur_in   = q_item.port_a[PW-1:0];
                        op_in    = OP_READ;
                        ret_in   = ST_DONE;
                        state_in = ST_PRD;
                     end else begin
                        state_in = ST_DONE;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FILT: begin
            excl_we = 1'b1;
            excl_wd = !item_ff.include_req;
            if (idx_ff[PW-1:0] == flast_ff) begin
               state_in = ST_DONE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_PA: begin
            op_in = (item_ff.kind == KIND_CONN) ? OP_CONN : OP_PKT;
            if (item_ff.port_a_ok) begin
               cur_in   = item_ff.port_a[PW-1:0];
               ret_in   = ST_PB;
               state_in = ST_PRD;
            end else begin
               has_a_in = 1'b0;
               state_in = ST_PB;
            end
         end
         ST_PB: begin
            op_in = (item_ff.kind == KIND_CONN) ? OP_CONN : OP_PKT;
            if (item_ff.port_b_ok) begin
               cur_in   = item_ff.port_b[PW-1:0];
               ret_in   = ST_PT;
               state_in = ST_PRD;
            end else begin
               has_b_in = 1'b0;
               state_in = ST_PT;
            end
         end
         ST_PT: begin
            // for a packet, the total record only moves when some port was included
            op_in = (item_ff.kind == KIND_CONN) ? OP_CONN : OP_PKT;
            if (item_ff.kind == KIND_CONN || has_a_ff || has_b_ff) begin
               cur_in   = '0;
               ret_in   = ST_POST;
               state_in = ST_PRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_PRD: begin
            state_in = ST_PWR;
         end
         ST_PWR: begin
            rec_we = op_ff != OP_READ;
            if (ret_ff == ST_PB) begin
               has_a_in = !excl_q;
            end
            if (ret_ff == ST_PT) begin
               has_b_in = !excl_q;
            end
            if (op_ff == OP_READ) begin
               res_in.port_seen = rec_q.touched;
               if (rec_q.touched) begin
                  res_in.last_bytes    = rec_q.lat_bytes;
                  res_in.last_packets  = rec_q.lat_packets;
                  res_in.last_active   = rec_q.lat_active;
                  res_in.total_bytes   = rec_q.tot_bytes;
                  res_in.total_packets = rec_q.tot_packets;
                  res_in.total_conns   = rec_q.tot_conns;
               end
            end
            state_in = ret_ff;
         end
         ST_POST: begin
            if (item_ff.kind == KIND_CONN) begin
               conn_we        = 1'b1;
               conn_wa        = cid_idx;
               conn_wd.valid  = 1'b1;
               conn_wd.active = 1'b0;
               conn_wd.has_a  = has_a_ff;
               conn_wd.has_b  = has_b_ff;
               conn_wd.pa     = has_a_ff ? item_ff.port_a : 16'd0;
               conn_wd.pb     = has_b_ff ? item_ff.port_b : 16'd0;
               state_in       = ST_DONE;
            end else if (item_ff.conn_ok) begin
               caddr_in = cid_idx;
               state_in = ST_MARK_RD;
            end else begin
               state_in = ST_AGE_CHECK;
            end
         end
         ST_MARK_RD: begin
            state_in = ST_MARK_WR;
         end
         ST_MARK_WR: begin
            conn_we        = conn_q.valid;
            conn_wd.active = 1'b1;
            state_in       = ST_AGE_CHECK;
         end
         ST_AGE_CHECK: begin
            if (item_ff.time_us > last_age_ff && age_delta > {8'd0, aging_period}) begin
               idx_in   = '0;
               caddr_in = '0;
               state_in = ST_SLOT_RD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_SLOT_RD: begin
            state_in = ST_SLOT_CHK;
         end
         ST_SLOT_CHK: begin
            slot_in  = conn_q;
            state_in = (conn_q.valid && conn_q.active) ? ST_SLOT_A : ST_SLOT_NEXT;
         end
         ST_SLOT_A: begin
            op_in = OP_ACT;
            if (slot_ff.has_a) begin
               cur_in   = slot_ff.pa[PW-1:0];
               ret_in   = ST_SLOT_B;
               state_in = ST_PRD;
            end else begin
               state_in = ST_SLOT_B;
            end
         end
         ST_SLOT_B: begin
            op_in = OP_ACT;
            if (slot_ff.has_b) begin
               cur_in   = slot_ff.pb[PW-1:0];
               ret_in   = ST_SLOT_T;
               state_in = ST_PRD;
            end else begin
               state_in = ST_SLOT_T;
            end
         end
         ST_SLOT_T: begin
            op_in    = OP_ACT;
            cur_in   = '0;
            ret_in   = ST_SLOT_WR;
            state_in = ST_PRD;
         end
         ST_SLOT_WR: begin
            conn_we        = 1'b1;
            conn_wa        = idx_ff[CW-1:0];
            conn_wd        = slot_ff;
            conn_wd.active = 1'b0;
            state_in       = ST_SLOT_NEXT;
         end
         ST_SLOT_NEXT: begin
            if (idx_ff == IW'(CONN_SLOTS - 1)) begin
               idx_in   = '0;
               state_in = ST_SWEEP;
            end else begin
               idx_in   = idx_ff + 1'b1;
               caddr_in = CW'(idx_ff[CW-1:0] + 1'b1);
               state_in = ST_SLOT_RD;
            end
         end
         ST_SWEEP: begin
            cur_in   = idx_ff[PW-1:0];
            op_in    = OP_AGE;
            ret_in   = ST_SWEEP_NEXT;
            state_in = ST_PRD;
         end
         ST_SWEEP_NEXT: begin
            if (idx_ff == IW'(PORT_COUNT - 1)) begin
               if (from_pkt_ff) begin
                  last_age_in = item_ff.time_us;
               end
               res_in.aged = 1'b1;
               state_in    = ST_DONE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_SWEEP;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = res_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         idx_ff       <= '0;
         last_age_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         last_age_ff  <= last_age_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff      <= ret_in;
      op_ff       <= op_in;
      item_ff     <= item_in;
      cur_ff      <= cur_in;
      caddr_ff    <= caddr_in;
      flast_ff    <= flast_in;
      has_a_ff    <= has_a_in;
      has_b_ff    <= has_b_in;
      from_pkt_ff <= from_pkt_in;
      slot_ff     <= slot_in;
      res_ff      <= res_in;
      rsp_res_ff  <= rsp_res_in;
   end

endmodule

FILE: tb/sv/traffic_stats_checker.sv
`timescale 1ns / 1ps
module traffic_stats_checker import pts_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   input  logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [2:0]            req_tuser,
   input  logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   input  logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_wr_en,
   input  logic [31:0]           csr_wr_data,
   output int                    errors,
   output int                    pending
);

   localparam int NPORTS = PORT_COUNT_DEFAULT;
   localparam int NSLOTS = CONN_SLOTS_DEFAULT;

   logic [31:0] aging_period;
   logic [39:0] last_age_time;
   bit          excluded [NPORTS];
   bit          touched [NPORTS];
   logic [39:0] cur_bytes [NPORTS];
   logic [31:0] cur_packets [NPORTS];
   logic [31:0] cur_active [NPORTS];
   logic [39:0] lat_bytes [NPORTS];
   logic [31:0] lat_packets [NPORTS];
   logic [11:0] lat_active [NPORTS];
   logic [63:0] sum_bytes [NPORTS];
   logic [47:0] sum_packets [NPORTS];
   logic [31:0] sum_conns [NPORTS];
   slot_type    slots [NSLOTS];

   result_type  expected_q [$];

   initial begin
      errors = 0;
      aging_period = AGE_INTERVAL_RESET;
      last_age_time = '0;
      for (int i = 0; i < NPORTS; i++) begin
         excluded[i] = 0;
         touched[i] = (i == 0);
         cur_bytes[i] = '0;
         cur_packets[i] = '0;
         cur_active[i] = '0;
         lat_bytes[i] = '0;
         lat_packets[i] = '0;
         lat_active[i] = '0;
         sum_bytes[i] = '0;
         sum_packets[i] = '0;
         sum_conns[i] = '0;
      end
      for (int i = 0; i < NSLOTS; i++) slots[i] = '0;
   end

   assign pending = expected_q.size();

   function automatic bit claim_port(logic [15:0] p);
      if (excluded[p]) return 0;
      touched[p] = 1;
      return 1;
   endfunction

   function automatic void add_packet(logic [15:0] p, logic [15:0] len);
      cur_bytes[p] = cur_bytes[p] + 40'(len);
      cur_packets[p] = cur_packets[p] + 1;
   endfunction

   function automatic void age_all();
      for (int i = 0; i < NSLOTS; i++) begin
         if (slots[i].valid && slots[i].active) begin
            if (slots[i].has_a) cur_active[slots[i].pa]++;
            if (slots[i].has_b) cur_active[slots[i].pb]++;
            cur_active[0]++;
            slots[i].active = 0;
         end
      end
      for (int i = 0; i < NPORTS; i++) begin
         if (touched[i]) begin
            lat_bytes[i] = cur_bytes[i];
            lat_packets[i] = cur_packets[i];
            lat_active[i] = cur_active[i][11:0];
            sum_bytes[i] = sum_bytes[i] + 64'(cur_bytes[i]);
            sum_packets[i] = sum_packets[i] + 48'(cur_packets[i]);
            cur_bytes[i] = '0;
            cur_packets[i] = '0;
            cur_active[i] = '0;
         end
      end
   endfunction

   function automatic result_type predict_stats(logic [2:0] cmd, logic [REQ_DATA_W-1:0] d);
      result_type  r;
      logic [15:0] pa, pb, len;
      logic        incl;
      logic [9:0]  cid;
      logic [39:0] t;
      bit          ha, hb;
      r = '0;
      pa = d[15:0];
      pb = d[31:16];
      incl = d[32];
      cid = d[42:33];
      len = d[58:43];
      t = d[98:59];
      case (cmd)
         CMD_SET_FILTER: begin
            for (int p = (pa == 0) ? 1 : int'(pa); p <= int'(pb); p++) excluded[p] = !incl;
         end
         CMD_NEW_CONN: begin
            ha = claim_port(pa);
            hb = claim_port(pb);
            slots[cid].valid = 1;
            slots[cid].active = 0;
            slots[cid].has_a = ha;
            slots[cid].has_b = hb;
            slots[cid].pa = ha ? pa : '0;
            slots[cid].pb = hb ? pb : '0;
            if (ha) sum_conns[pa]++;
            if (hb) sum_conns[pb]++;
            sum_conns[0]++;
         end
         CMD_PACKET: begin
            ha = claim_port(pa);
            hb = claim_port(pb);
            if (ha || hb) begin
               if (slots[cid].valid) slots[cid].active = 1;
               if (ha) add_packet(pa, len);
               if (hb) add_packet(pb, len);
               add_packet(16'd0, len);
               if (t > last_age_time && (t - last_age_time) > 40'(aging_period)) begin
                  age_all();
                  last_age_time = t;
                  r.aged = 1;
               end
            end
         end
         CMD_FLUSH_AGE: begin
            age_all();
            r.aged = 1;
         end
         CMD_READ_PORT: begin
            if (touched[pa]) begin
               r.port_seen = 1;
               r.last_bytes = lat_bytes[pa];
               r.last_packets = lat_packets[pa];
               r.last_active = lat_active[pa];
               r.total_bytes = sum_bytes[pa];
               r.total_packets = sum_packets[pa];
               r.total_conns = sum_conns[pa];
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      result_type exp_r;
      if (!reset) begin
         // a register write on this edge is in place before the transaction is processed
         if (csr_wr_en) aging_period = csr_wr_data;
         if (rsp_tvalid && rsp_tready) begin
            if (expected_q.size() == 0) begin
               $error("response transaction with nothing expected");
               errors++;
            end else begin
               exp_r = expected_q.pop_front();
               if (rsp_tdata[0] !== exp_r.port_seen) begin
                  $error("port_seen: expected %0h, got %0h", exp_r.port_seen, rsp_tdata[0]);
                  errors++;
               end
               if (rsp_tdata[40:1] !== exp_r.last_bytes) begin
                  $error("last_bytes: expected %0h, got %0h", exp_r.last_bytes,
                         rsp_tdata[40:1]);
                  errors++;
               end
               if (rsp_tdata[72:41] !== exp_r.last_packets) begin
                  $error("last_packets: expected %0h, got %0h", exp_r.last_packets,
                         rsp_tdata[72:41]);
                  errors++;
               end
               if (rsp_tdata[84:73] !== exp_r.last_active) begin
                  $error("last_active: expected %0h, got %0h", exp_r.last_active,
                         rsp_tdata[84:73]);
                  errors++;
               end
               if (rsp_tdata[148:85] !== exp_r.total_bytes) begin
                  $error("total_bytes: expected %0h, got %0h", exp_r.total_bytes,
                         rsp_tdata[148:85]);
                  errors++;
               end
               if (rsp_tdata[196:149] !== exp_r.total_packets) begin
                  $error("total_packets: expected %0h, got %0h", exp_r.total_packets,
                         rsp_tdata[196:149]);
                  errors++;
               end
               if (rsp_tdata[228:197] !== exp_r.total_conns) begin
                  $error("total_conns: expected %0h, got %0h", exp_r.total_conns,
                         rsp_tdata[228:197]);
                  errors++;
               end
               if (rsp_tdata[229] !== exp_r.aged) begin
                  $error("aged: expected %0h, got %0h", exp_r.aged, rsp_tdata[229]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_q.push_back(predict_stats(req_tuser, req_tdata));
         end
      end
   end

endmodule

FILE: tb/sv/per_port_traffic_statistics_tb.sv
`timescale 1ns / 1ps
module per_port_traffic_statistics_tb;
   import pts_pkg::*;

   localparam int CYCLE_LIMIT = 20000000;

   logic                  clock = 0;
   logic                  reset = 1;
   logic                  req_tvalid = 0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [2:0]            req_tuser = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_wr_en = 0;
   logic [31:0]           csr_wr_data = '0;
   int                    errors;
   int                    pending;
   int                    cycles = 0;
   int                    burst_left = 0;
   int                    stall_mode = 0;
   int                    flush_at;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   per_port_traffic_statistics dut (.*);

   traffic_stats_checker checker_i (.*);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("per_port_traffic_statistics regression: fail");
         $finish;
      end
   end

   // receiver backpressure in one of four randomly picked modes
   always @(posedge clock) begin
      if (cycles % 64 == 0) stall_mode <= $urandom_range(0, 3);
      case (stall_mode)
         0: rsp_tready <= 1'b1;
         1: rsp_tready <= ($urandom_range(0, 1) == 1);
         2: rsp_tready <= ($urandom_range(0, 7) != 0);
         default: rsp_tready <= (cycles % 16) < 4;
      endcase
   end

   task automatic send_cmd(logic [2:0] cmd, logic [15:0] pa, logic [15:0] pb, logic incl,
                           logic [9:0] cid, logic [15:0] len, logic [39:0] t);
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {5'b0, t, len, cid, incl, pb, pa};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_interval(logic [31:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] pick_port();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return 16'hFFFF;
         2: return 16'd0;
         default: return 16'($urandom_range(1, 15));
      endcase
   endfunction

   task automatic random_items(int count, bit with_flush);
      logic [15:0] pa, pb, lo;
      logic [2:0]  cmd;
      int          sel;
      flush_at = $urandom_range(count / 4, 3 * count / 4);
      for (int n = 0; n < count; n++) begin
         if (with_flush && n == flush_at) begin
            // wait for the pipeline to empty before the aging pass
            drain();
            send_cmd(CMD_FLUSH_AGE, 16'($urandom), 16'($urandom), 1'($urandom),
                     10'($urandom), 16'($urandom), {8'($urandom), 32'($urandom)});
            continue;
         end
         sel = $urandom_range(0, 99);
         pa = pick_port();
         pb = pick_port();
         if (sel < 25) cmd = CMD_NEW_CONN;
         else if (sel < 70) cmd = CMD_PACKET;
         else if (sel < 90) cmd = CMD_READ_PORT;
         else if (sel < 97) begin
            // short filter ranges keep the walk cheap
            cmd = CMD_SET_FILTER;
            lo = 16'($urandom_range(0, 20));
            pa = lo;
            pb = lo + 16'($urandom_range(0, 6));
         end else cmd = 3'($urandom_range(5, 7));
         send_cmd(cmd, pa, pb, 1'($urandom_range(0, 3) != 0),
                  ($urandom_range(0, 3) == 0) ? 10'($urandom) : 10'($urandom_range(0, 31)),
                  16'($urandom), {8'($urandom), 32'($urandom)});
      end
      drain();
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_cmd(CMD_READ_PORT, 16'd0, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_READ_PORT, 16'hFFFF, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      drain();
      write_interval(32'd1);
      send_cmd(CMD_NEW_CONN, 16'd1, 16'hFFFF, 1'b1, 10'd0, 16'd0, 40'd0);
      // time exactly one interval past the last aging does not age
      send_cmd(CMD_PACKET, 16'd1, 16'hFFFF, 1'b0, 10'd0, 16'hFFFF, 40'd1);
      // port zero named in a packet, slot never opened
      send_cmd(CMD_PACKET, 16'd0, 16'd2, 1'b1, 10'd1023, 16'd0, 40'd2);
      send_cmd(CMD_READ_PORT, 16'd1, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_READ_PORT, 16'd0, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_FLUSH_AGE, 16'hFFFF, 16'hFFFF, 1'b1, 10'h3FF, 16'hFFFF, 40'hFF_FFFF_FFFF);
      send_cmd(CMD_READ_PORT, 16'hFFFF, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_SET_FILTER, 16'd0, 16'hFFFF, 1'b0, 10'd0, 16'd0, 40'd0);
      // both ports excluded: ignored, no aging even far in the future
      send_cmd(CMD_PACKET, 16'd7, 16'd9, 1'b0, 10'd0, 16'd100, 40'hFF_FFFF_FFFE);
      send_cmd(CMD_NEW_CONN, 16'd7, 16'd9, 1'b0, 10'd1023, 16'd0, 40'd0);
      send_cmd(CMD_SET_FILTER, 16'd9, 16'd7, 1'b1, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_READ_PORT, 16'd7, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_SET_FILTER, 16'd0, 16'hFFFF, 1'b1, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_PACKET, 16'hFFFF, 16'd0, 1'b0, 10'd0, 16'h8000, 40'hFF_FFFF_FFFF);
      send_cmd(CMD_SET_FILTER, 16'd2, 16'd2, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(CMD_PACKET, 16'd2, 16'd3, 1'b0, 10'd0, 16'd5, 40'd3);
      send_cmd(CMD_READ_PORT, 16'd2, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      send_cmd(3'd5, 16'd1, 16'd1, 1'b1, 10'd1, 16'd1, 40'd1);
      send_cmd(3'd6, 16'd1, 16'd1, 1'b1, 10'd1, 16'd1, 40'd1);
      send_cmd(3'd7, 16'd1, 16'd1, 1'b1, 10'd1, 16'd1, 40'd1);
      send_cmd(CMD_READ_PORT, 16'd1, 16'd0, 1'b0, 10'd0, 16'd0, 40'd0);
      drain();

      // last aging time now sits at the top, so random times never age
      write_interval(32'hFFFF_FFFF);
      random_items(350, 1'b0);
      write_interval(32'($urandom));
      random_items(350, 1'b1);
      write_interval(32'd1);
      random_items(350, 1'b0);
      repeat (50) @(posedge clock);

      if (errors == 0) begin
         $display("per_port_traffic_statistics regression: pass");
      end else begin
         $display("per_port_traffic_statistics regression: fail");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/pts_pkg.sv
hdl/pts_front.sv
hdl/pts_back.sv
hdl/per_port_traffic_statistics.sv
tb/sv/traffic_stats_checker.sv
tb/sv/per_port_traffic_statistics_tb.sv
